// ===== rtl/sorted_quartile_engine_top_defines.svh =====
// Assertion macros shared by the checker of the sorted quartile engine.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef SORTED_QUARTILE_ENGINE_TOP_DEFINES_SVH
`define SORTED_QUARTILE_ENGINE_TOP_DEFINES_SVH

// A property that must hold at every rising edge outside reset.
`define SQE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a rising edge outside reset.
`define SQE_NEVER(lbl, clk, rst_n, cond, msg) \
    `SQE_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/sqe_pkg.sv =====
// Package of the sorted quartile engine: store geometry, field widths and FSM states.
// Used by sorted_quartile_engine_top and sqe_checker; depends on nothing.
`default_nettype none

package sqe_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    // Wide enough for 3 * (STORE_DEPTH + 1).
    localparam int POS_W       = $clog2(STORE_DEPTH + 2) + 2;
    localparam int VAL_W       = 32;
    localparam int QQ_W        = 34;
    localparam int SEL_W       = 2;
    localparam int ACC_W       = VAL_W + 4;

    localparam logic [SEL_W-1:0] SEL_NONE = 2'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_CALC,
        S_FETCH_LO,
        S_FETCH_HI
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/sorted_quartile_engine_top.sv =====
// Sorted quartile engine: keeps the batch sorted in a single-port-read memory as
// words arrive and gives quartile 1, 2 or 3 in quarters on the last word.
// Depends on sqe_pkg.
//
// Each word is inserted into the sorted store when it is accepted (start high while
// busy is low). Insertion reads one entry per cycle from the synchronous store and
// shifts each stored entry greater than it up by one (at most STORE_DEPTH - 1 of
// them). A word arriving while the store is full is dropped and flagged. For the
// last word of a batch a quartile is then worked out: first the interpolation
// indices, then two reads of the store; with a bad selector only the first step is
// taken. The result sits on the output ports for exactly one cycle, marked by
// o_valid, in the first cycle in which busy is low again; there is no back-pressure,
// so the receiver must take it then. The count and the drop flag clear with each result.
`default_nettype none

module sorted_quartile_engine_top
    import sqe_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire logic                    i_last,
    input  wire logic [SEL_W-1:0]        i_which_quartile,
    output logic                         busy,
    output logic                         o_valid,
    output logic signed [QQ_W-1:0]       o_quartile_quarters,
    output logic                         o_empty_res,
    output logic                         o_overflow,
    output logic                         o_bad_select
);

    logic signed [VAL_W-1:0] mem [STORE_DEPTH];

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_drop, n_drop;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic [ADDR_W-1:0]       r_j, n_j;
    logic                    r_last, n_last;
    logic [SEL_W-1:0]        r_sel, n_sel;
    logic signed [VAL_W-1:0] r_lo, n_lo;
    logic [ADDR_W-1:0]       r_idx_hi, n_idx_hi;
    logic [1:0]              r_rem, n_rem;
    logic signed [VAL_W-1:0] r_rdata;
    logic                    r_valid, n_valid;
    logic signed [QQ_W-1:0]  r_qq, n_qq;
    logic                    r_empty, n_empty;
    logic                    r_ovf, n_ovf;
    logic                    r_bad, n_bad;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic signed [VAL_W-1:0] w_wdata;
    logic [ADDR_W-1:0]       w_raddr;
    logic                    w_greater;
    logic                    w_no_result;

    logic [POS_W-1:0]        w_n1;
    logic [POS_W-1:0]        w_prod;
    logic [POS_W-1:0]        w_pos;
    logic [POS_W-1:0]        w_nm1;
    logic [POS_W-1:0]        w_lo_raw;
    logic [POS_W-1:0]        w_lo_idx;
    logic [POS_W-1:0]        w_hi_idx;

    logic signed [ACC_W-1:0] w_lo_x;
    logic signed [ACC_W-1:0] w_hi_x;
    logic signed [ACC_W-1:0] w_diff;
    logic signed [ACC_W-1:0] w_interp;

    assign w_accept    = start && (r_state == S_IDLE);
    assign w_full      = (r_cnt == CNT_W'(STORE_DEPTH));
    assign w_greater   = (r_rdata > r_key);
    assign w_no_result = (r_cnt == '0) || (r_sel == SEL_NONE);

    // Position q*(n+1)/4 and its remainder; indices are clamped into the batch.
    assign w_n1     = POS_W'(r_cnt) + POS_W'(1);
    assign w_prod   = w_n1 * POS_W'(r_sel);
    assign w_pos    = w_prod >> 2;
    assign w_nm1    = POS_W'(r_cnt) - POS_W'(1);
    assign w_lo_raw = (w_pos == '0) ? '0 : (w_pos - POS_W'(1));
    assign w_lo_idx = (w_lo_raw > w_nm1) ? w_nm1 : w_lo_raw;
    assign w_hi_idx = (w_pos > w_nm1) ? w_nm1 : w_pos;

    // Four times the lower element plus remainder times the step to the upper one.
    assign w_lo_x   = {{(ACC_W-VAL_W){r_lo[VAL_W-1]}}, r_lo};
    assign w_hi_x   = {{(ACC_W-VAL_W){r_rdata[VAL_W-1]}}, r_rdata};
    assign w_diff   = w_hi_x - w_lo_x;
    assign w_interp = (w_lo_x <<< 2)
                    + (r_rem[1] ? (w_diff <<< 1) : ACC_W'(0))
                    + (r_rem[0] ? w_diff : ACC_W'(0));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!w_full) begin
                        n_state = (r_cnt == '0) ? S_PLACE : S_SHIFT;
                    end else begin
                        n_state = i_last ? S_CALC : S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                if (w_greater) begin
                    n_state = (r_j == ADDR_W'(1)) ? S_PLACE : S_SHIFT;
                end else begin
                    n_state = r_last ? S_CALC : S_IDLE;
                end
            end
            S_PLACE:    n_state = r_last ? S_CALC : S_IDLE;
            S_CALC:     n_state = w_no_result ? S_IDLE : S_FETCH_LO;
            S_FETCH_LO: n_state = S_FETCH_HI;
            S_FETCH_HI: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_drop   = r_drop;
        n_key    = r_key;
        n_j      = r_j;
        n_last   = r_last;
        n_sel    = r_sel;
        n_lo     = r_lo;
        n_idx_hi = r_idx_hi;
        n_rem    = r_rem;
        n_valid  = 1'b0;
        n_qq     = r_qq;
        n_empty  = r_empty;
        n_ovf    = r_ovf;
        n_bad    = r_bad;
        w_we     = 1'b0;
        w_waddr  = r_j;
        w_wdata  = r_key;
        w_raddr  = r_j - ADDR_W'(1);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key  = i_value;
                    n_last = i_last;
                    n_sel  = i_which_quartile;
                    if (!w_full) begin
                        n_j     = r_cnt[ADDR_W-1:0];
                        n_cnt   = r_cnt + CNT_W'(1);
                        w_raddr = r_cnt[ADDR_W-1:0] - ADDR_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                // The entry below the hole is in r_rdata; move it up or drop the key in.
                w_we = 1'b1;
                if (w_greater) begin
                    w_wdata = r_rdata;
                    n_j     = r_j - ADDR_W'(1);
                    w_raddr = r_j - ADDR_W'(2);
                end
            end
            S_PLACE: begin
                w_we = 1'b1;
            end
            S_CALC: begin
                if (w_no_result) begin
                    n_valid = 1'b1;
                    n_qq    = '0;
                    n_empty = (r_cnt == '0);
                    n_ovf   = r_drop;
                    n_bad   = (r_sel == SEL_NONE);
                    n_cnt   = '0;
                    n_drop  = 1'b0;
                end else begin
                    w_raddr  = w_lo_idx[ADDR_W-1:0];
                    n_idx_hi = w_hi_idx[ADDR_W-1:0];
                    n_rem    = w_prod[1:0];
                end
            end
            S_FETCH_LO: begin
                n_lo    = r_rdata;
                w_raddr = r_idx_hi;
            end
            S_FETCH_HI: begin
                n_valid = 1'b1;
                n_qq    = w_interp[QQ_W-1:0];
                n_empty = 1'b0;
                n_ovf   = r_drop;
                n_bad   = 1'b0;
                n_cnt   = '0;
                n_drop  = 1'b0;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_j      <= n_j;
        r_last   <= n_last;
        r_sel    <= n_sel;
        r_lo     <= n_lo;
        r_idx_hi <= n_idx_hi;
        r_rem    <= n_rem;
        r_qq     <= n_qq;
        r_empty  <= n_empty;
        r_ovf    <= n_ovf;
        r_bad    <= n_bad;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_valid             = r_valid;
    assign o_quartile_quarters = r_qq;
    assign o_empty_res         = r_empty;
    assign o_overflow          = r_ovf;
    assign o_bad_select        = r_bad;

endmodule

`default_nettype wire

// ===== rtl/sqe_checker.sv =====
// Port-level checker for the sorted quartile engine, bound to the top level.
// Depends on sqe_pkg and sorted_quartile_engine_top_defines.svh.
`default_nettype none

`include "sorted_quartile_engine_top_defines.svh"

module sqe_checker
    import sqe_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic                   o_valid,
    input wire logic signed [QQ_W-1:0] o_quartile_quarters,
    input wire logic                   o_empty_res,
    input wire logic                   o_overflow,
    input wire logic                   o_bad_select
);

    // A result is only strobed once the engine has returned to waiting for words.
    `SQE_ASSERT(a_valid_not_busy, i_clk, i_rst_n, o_valid |-> !busy, "result while busy")

    // Every result needs fresh work, so two strobes never sit back to back.
    `SQE_ASSERT(a_valid_single, i_clk, i_rst_n, o_valid |=> !o_valid, "adjacent results")

    // A rejected selector or an empty batch always reads as zero.
    `SQE_NEVER(a_bad_zero, i_clk, i_rst_n,
        o_valid && (o_bad_select || o_empty_res) && (o_quartile_quarters != '0),
        "flagged result not zero")

    // A word accepted while no result is on the ports never yields a result straight away.
    `SQE_ASSERT(a_start_no_result, i_clk, i_rst_n,
        (start && !busy && !o_valid) |=> !o_valid, "result without a last word")

endmodule

bind sorted_quartile_engine_top sqe_checker u_sqe_checker (.*);

`default_nettype wire
